// File: sv/sll_pkg.sv
// Shared types and codes for the sorted list priority queue.
// No dependencies; every other file imports this package.
package sll_pkg;

  localparam logic [1:0] REQ_INSERT     = 2'd0;
  localparam logic [1:0] REQ_REMOVE_MIN = 2'd1;
  localparam logic [1:0] REQ_REMOVE_MAX = 2'd2;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT_DOWN
  } cell_op_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [4:0]         entry_count;
    logic signed [31:0] smallest_value;
    logic signed [31:0] largest_value;
  } out_word_t;

endpackage

// File: sv/sll_cell.sv
// One storage cell of the sorted row: holds a value, compares it with the
// value being inserted and trades data with its neighbors. Uses sll_pkg.
module sll_cell (
  input  logic                clk,
  input  sll_pkg::cell_op_t   op,
  input  logic signed [31:0]  ins_value,
  input  logic                occ,
  input  logic                left_lt,
  input  logic signed [31:0]  left_val,
  input  logic signed [31:0]  right_val,
  output logic signed [31:0]  val_q,
  output logic                lt
);
  import sll_pkg::*;

  logic signed [31:0] val_r;
  logic signed [31:0] val_nxt;

  // this cell sits ahead of the insertion point
  assign lt    = occ && (val_r < ins_value);
  assign val_q = val_r;

  always_comb begin
    val_nxt = val_r;
    case (op)
      CELL_INSERT: begin
        if (lt) begin
          val_nxt = val_r;
        end else if (left_lt) begin
          val_nxt = ins_value;
        end else begin
          val_nxt = left_val;
        end
      end
      CELL_SHIFT_DOWN: val_nxt = right_val;
      default:         val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// File: sv/sorted_list_insert_remove_top.sv
// Sorted list priority queue built as a row of compare-and-shift cells.
// The row and the request registers update at the accepting edge; the output
// register loads from the row at a later edge, once the result word can move.
// A new request is stalled until the pending one has loaded the output register.
// A stalled result word holds the next request pending until the word drains.
// Reset clears the entry count and the handshake state; cell contents are undefined.
module sorted_list_insert_remove_top #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sll_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sll_pkg::out_word_t out_data
);
  import sll_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]      count_r, count_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         req_r, req_nxt;
  logic [1:0]         status_r, status_nxt;
  logic signed [31:0] rem_min_r, rem_min_nxt;
  out_word_t          out_r, out_nxt;

  logic               in_acc;
  logic               load_out;
  logic               full;
  logic               empty;
  cell_op_t           cell_op;

  logic signed [31:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_occ;
  logic [CAPACITY-1:0] last_hit;
  logic [CAPACITY-1:0] rem_hit;

  logic signed [31:0] largest_sel;
  logic signed [31:0] removed_sel;
  logic [CW+4:0]      count_ext;

  assign in_acc    = in_valid && !in_stall;
  // the row stays put while a request waits for the output register
  assign in_stall  = pend_r;
  assign load_out  = pend_r && (!out_valid_r || !out_stall);
  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // request decode and row command
  always_comb begin
    status_nxt  = status_r;
    req_nxt     = req_r;
    rem_min_nxt = rem_min_r;
    count_nxt   = count_r;
    cell_op     = CELL_HOLD;
    if (in_acc) begin
      req_nxt     = in_data.req_type;
      status_nxt  = STAT_DONE;
      rem_min_nxt = cell_val[0];
      case (in_data.req_type)
        REQ_INSERT: begin
          if (full) begin
            status_nxt = STAT_FULL;
          end else begin
            cell_op   = CELL_INSERT;
            count_nxt = count_r + CW'(1);
          end
        end
        REQ_REMOVE_MIN: begin
          if (empty) begin
            status_nxt = STAT_EMPTY;
          end else begin
            cell_op   = CELL_SHIFT_DOWN;
            count_nxt = count_r - CW'(1);
          end
        end
        REQ_REMOVE_MAX: begin
          if (empty) begin
            status_nxt = STAT_EMPTY;
          end else begin
            count_nxt = count_r - CW'(1);
          end
        end
        default: status_nxt = STAT_DONE;
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      assign cell_occ[gi] = (CW'(gi) < count_r);
      assign last_hit[gi] = (CW'(gi + 1) == count_r);
      assign rem_hit[gi]  = (CW'(gi) == count_r);

      if (gi == 0) begin : g_head
        // the head sees a smaller-than-everything boundary on its left
        sll_cell u_cell (
          .clk       (clk),
          .op        (cell_op),
          .ins_value (in_data.value),
          .occ       (cell_occ[gi]),
          .left_lt   (1'b1),
          .left_val  (in_data.value),
          .right_val (cell_val[(gi + 1 < CAPACITY) ? gi + 1 : gi]),
          .val_q     (cell_val[gi]),
          .lt        (cell_lt[gi])
        );
      end else begin : g_body
        sll_cell u_cell (
          .clk       (clk),
          .op        (cell_op),
          .ins_value (in_data.value),
          .occ       (cell_occ[gi]),
          .left_lt   (cell_lt[gi-1]),
          .left_val  (cell_val[gi-1]),
          .right_val (cell_val[(gi + 1 < CAPACITY) ? gi + 1 : gi]),
          .val_q     (cell_val[gi]),
          .lt        (cell_lt[gi])
        );
      end
    end
  endgenerate

  // one-hot picks of the back cell and of the cell just dropped off the back
  always_comb begin
    largest_sel = '0;
    removed_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (last_hit[i]) largest_sel = largest_sel | cell_val[i];
      if (rem_hit[i])  removed_sel = removed_sel | cell_val[i];
    end
  end

  assign count_ext = {5'b0, count_r};

  always_comb begin
    out_nxt = out_r;
    if (load_out) begin
      out_nxt.status        = status_r;
      out_nxt.entry_count   = count_ext[4:0];
      out_nxt.removed_value = '0;
      if (status_r == STAT_DONE) begin
        if (req_r == REQ_REMOVE_MIN) begin
          out_nxt.removed_value = rem_min_r;
        end else if (req_r == REQ_REMOVE_MAX) begin
          out_nxt.removed_value = removed_sel;
        end
      end
      out_nxt.smallest_value = empty ? 32'sd0 : cell_val[0];
      out_nxt.largest_value  = empty ? 32'sd0 : largest_sel;
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc) begin
      pend_nxt = 1'b1;
    end else if (load_out) begin
      pend_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    status_r  <= status_nxt;
    rem_min_r <= rem_min_nxt;
    out_r     <= out_nxt;
  end

endmodule
